// ===== sv/throttle_clamp_speed_interpolator_top_assert.svh =====
// assertion macros for the throttle clamp and speed interpolator
`ifndef THROTTLE_CLAMP_SPEED_INTERPOLATOR_TOP_ASSERT_SVH
`define THROTTLE_CLAMP_SPEED_INTERPOLATOR_TOP_ASSERT_SVH

// concurrent assertion on a given clock and active-low reset
`define TCSI_ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("tcsi assertion failed");

// concurrent assertion on the block clock and reset
`define TCSI_ASSERT(lbl, prop) \
  `TCSI_ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`endif

// ===== sv/tcsi_pkg.sv =====
// shared types and constants for the throttle clamp and speed interpolator
package tcsi_pkg;

  localparam int KIND_W  = 2;
  localparam int REQ_W   = 9;
  localparam int PWR_W   = 8;
  localparam int SPD_W   = 16;
  localparam int OUT_W   = 24;
  localparam int CFG_W   = 16;
  localparam int IDX_W   = 3;
  localparam int NUM_PTS = 5;
  localparam int NUM_W   = 21;
  localparam int SPEED_FRACTION_BITS_DEF = 8;

  typedef enum logic [KIND_W-1:0] {
    KIND_SET  = 2'd0,
    KIND_INC  = 2'd1,
    KIND_DEC  = 2'd2,
    KIND_HOLD = 2'd3
  } kind_e;

  typedef enum logic [IDX_W-1:0] {
    REG_LIMIT  = 3'd0,
    REG_FLOOR  = 3'd1,
    REG_STEP   = 3'd2,
    REG_SPD0   = 3'd3,
    REG_SPD32  = 3'd4,
    REG_SPD64  = 3'd5,
    REG_SPD96  = 3'd6,
    REG_SPD127 = 3'd7
  } reg_idx_e;

  typedef logic [SPD_W-1:0] spd_arr_t [NUM_PTS];

  typedef struct packed {
    logic             valid;
    logic [PWR_W-1:0] power;
  } pwr_stage_t;

  localparam logic [PWR_W-1:0] BP_T [NUM_PTS] = '{8'd0, 8'd32, 8'd64, 8'd96, 8'd127};
  localparam logic [SPD_W-1:0] SPEED_RST [NUM_PTS] =
    '{16'd0, 16'd0, 16'd830, 16'd1480, 16'd1900};

  localparam logic [PWR_W-1:0] LIMIT_RST = 8'd127;
  localparam logic [PWR_W-1:0] FLOOR_RST = 8'd32;
  localparam logic [PWR_W-1:0] STEP_RST  = 8'd8;

endpackage

// ===== sv/tcsi_req_if.sv =====
// request channel: command kind and requested throttle
interface tcsi_req_if import tcsi_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [KIND_W-1:0]       kind;
  logic signed [REQ_W-1:0] requested_throttle;

  modport source (output valid, kind, requested_throttle, input ready);
  modport sink (input valid, kind, requested_throttle, output ready);
endinterface

// ===== sv/tcsi_res_if.sv =====
// result channel: clamped throttle power and interpolated speed
interface tcsi_res_if import tcsi_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PWR_W-1:0] throttle_power;
  logic [OUT_W-1:0] speed_q8;

  modport source (output valid, throttle_power, speed_q8, input ready);
  modport sink (input valid, throttle_power, speed_q8, output ready);
endinterface

// ===== sv/tcsi_interp.sv =====
// two-stage piecewise linear speed interpolation with output register
module tcsi_interp import tcsi_pkg::*; #(
  parameter int FRAC_BITS = SPEED_FRACTION_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  pwr_stage_t       stg_i,
  input  spd_arr_t         spd_i,
  output pwr_stage_t       stg_o,
  output logic [OUT_W-1:0] speed_o
);

  localparam int QW    = NUM_W + FRAC_BITS;
  localparam int QN_W  = NUM_W - 4;
  localparam int RSH   = NUM_W + 5;
  localparam int PRD_W = 2 * NUM_W + 1;
  localparam logic [NUM_W:0] RECIP =
    (NUM_W + 1)'(((64'd1 << RSH) + 64'd30) / 64'd31);

  // segment select and weighted sum
  pwr_stage_t       s2_q;
  logic [NUM_W-1:0] num_d, num_q;
  logic             span31_d, span31_q;
  logic             zero_d, zero_q;
  logic [1:0]       seg;
  logic [2:0]       seg_lo, seg_hi;
  logic [5:0]       dlo, dhi;
  logic [21:0]      p0, p1;

  always_comb begin
    if (stg_i.power <= BP_T[1]) begin
      seg = 2'd0;
    end else if (stg_i.power <= BP_T[2]) begin
      seg = 2'd1;
    end else if (stg_i.power <= BP_T[3]) begin
      seg = 2'd2;
    end else begin
      seg = 2'd3;
    end
    seg_lo   = 3'(seg);
    seg_hi   = 3'(seg) + 3'd1;
    dlo      = 6'(stg_i.power - BP_T[seg_lo]);
    dhi      = 6'(BP_T[seg_hi] - stg_i.power);
    p0       = 22'(spd_i[seg_lo]) * 22'(dhi);
    p1       = 22'(spd_i[seg_hi]) * 22'(dlo);
    num_d    = NUM_W'(p0 + p1);
    span31_d = (seg == 2'd3);
    zero_d   = (stg_i.power > BP_T[NUM_PTS-1]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_q <= '0;
    end else if (en_i) begin
      s2_q <= stg_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q      <= num_d;
      span31_q   <= span31_d;
      zero_q     <= zero_d;
    end
  end

  // scale by the fraction and divide by the span
  logic [2*NUM_W:0] prod;
  logic [QN_W-1:0]  qn;
  logic [NUM_W-1:0] qn31, rem;
  logic [4:0]       r5;
  logic [2:0]       k;
  logic [QW-1:0]    frac, q31, q32, q;
  logic [OUT_W-1:0] spd_d;
  pwr_stage_t       s3_q;
  logic [OUT_W-1:0] spd_q;

  always_comb begin
    prod = PRD_W'(num_q) * PRD_W'(RECIP);
    qn   = QN_W'(prod >> RSH);
    qn31 = NUM_W'({qn, 5'b0}) - NUM_W'(qn);
    rem  = num_q - qn31;
    if (rem >= NUM_W'(31)) begin
      qn  = qn + QN_W'(1);
      rem = rem - NUM_W'(31);
    end
    r5   = 5'(rem);
    // a remainder over 31 repeats its five bits in the binary fraction
    frac = '0;
    k    = 3'd4;
    for (int j = 0; j < FRAC_BITS; j++) begin
      frac = {frac[QW-2:0], r5[k]};
      k    = (k == 3'd0) ? 3'd4 : k - 3'd1;
    end
    q31 = (QW'(qn) << FRAC_BITS) | frac;
    q32 = (QW'(num_q) << FRAC_BITS) >> 5;
    q   = span31_q ? q31 : q32;
    if (zero_q) begin
      spd_d = '0;
    end else if ((q >> OUT_W) != '0) begin
      spd_d = '1;
    end else begin
      spd_d = OUT_W'(q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_q <= '0;
    end else if (en_i) begin
      s3_q <= s2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      spd_q      <= spd_d;
    end
  end

  assign stg_o   = s3_q;
  assign speed_o = spd_q;

endmodule

// ===== sv/throttle_clamp_speed_interpolator_top.sv =====
// Throttle clamp and speed interpolator, top level.
// Requests arrive on req: kind (set, increment, decrement, hold) and a signed
// requested throttle used by set requests. Each accepted request updates the
// throttle power register at once, clamps it against limit and floor, and
// gives exactly one result on res: the clamped power and its speed in
// unsigned fixed point, interpolated between breakpoints 0, 32, 64, 96, 127.
// Throughput is one request per cycle while res does not stall; the power
// update is a single add and clamp ahead of the first pipeline register, so
// consecutive requests chain. From acceptance to the result showing valid a
// request passes the power register, weighted sum stage (two 16x6 products)
// and divide-by-span stage (reciprocal multiply for the last segment) into
// the output register. When res stalls the whole pipeline holds and req.ready
// drops; the output register keeps its payload stable until taken.
// Reset empties the pipeline, clears the power to zero and loads the
// configuration registers with their defaults. Configuration is written on
// cfg_we_i by index and should only change while no result is outstanding.
module throttle_clamp_speed_interpolator_top import tcsi_pkg::*; #(
  parameter int SPEED_FRACTION_BITS = SPEED_FRACTION_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  tcsi_req_if.sink         req,
  tcsi_res_if.source       res,
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i
);

  logic [PWR_W-1:0] limit_q, floor_q, step_q;
  spd_arr_t         spd_q;
  logic [PWR_W-1:0] power_d, power_q;
  logic             en, accept;
  pwr_stage_t       s1_q, stg_out;
  logic [OUT_W-1:0] speed;

  function automatic logic [PWR_W-1:0] clamp_power(
    input logic signed [PWR_W+1:0] cand,
    input logic [PWR_W-1:0]        lim,
    input logic [PWR_W-1:0]        flr
  );
    logic [PWR_W-1:0] res_v;
    if (cand > $signed({2'b00, lim})) begin
      res_v = lim;
    end else if (cand > 0 && cand <= $signed({2'b00, flr})) begin
      res_v = flr;
    end else if (cand < 0) begin
      res_v = '0;
    end else begin
      res_v = cand[PWR_W-1:0];
    end
    return res_v;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RST;
      floor_q <= FLOOR_RST;
      step_q  <= STEP_RST;
      for (int i = 0; i < NUM_PTS; i++) begin
        spd_q[i] <= SPEED_RST[i];
      end
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_LIMIT:  limit_q  <= cfg_wdata_i[PWR_W-1:0];
        REG_FLOOR:  floor_q  <= cfg_wdata_i[PWR_W-1:0];
        REG_STEP:   step_q   <= cfg_wdata_i[PWR_W-1:0];
        REG_SPD0:   spd_q[0] <= cfg_wdata_i[SPD_W-1:0];
        REG_SPD32:  spd_q[1] <= cfg_wdata_i[SPD_W-1:0];
        REG_SPD64:  spd_q[2] <= cfg_wdata_i[SPD_W-1:0];
        REG_SPD96:  spd_q[3] <= cfg_wdata_i[SPD_W-1:0];
        REG_SPD127: spd_q[4] <= cfg_wdata_i[SPD_W-1:0];
        default: ;
      endcase
    end
  end

  assign en        = !res.valid || res.ready;
  assign accept    = req.valid && en;
  assign req.ready = en;

  always_comb begin
    case (kind_e'(req.kind))
      KIND_SET: begin
        power_d = clamp_power((PWR_W+2)'(req.requested_throttle), limit_q, floor_q);
      end
      KIND_INC: begin
        if (power_q == '0) begin
          power_d = clamp_power($signed({2'b00, floor_q}), limit_q, floor_q);
        end else begin
          power_d = clamp_power($signed({2'b00, power_q} + {2'b00, step_q}),
                                limit_q, floor_q);
        end
      end
      KIND_DEC: begin
        if (power_q <= floor_q) begin
          power_d = '0;
        end else begin
          power_d = clamp_power($signed({2'b00, power_q} - {2'b00, step_q}),
                                limit_q, floor_q);
        end
      end
      default: power_d = power_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      power_q <= '0;
      s1_q    <= '0;
    end else begin
      if (accept) begin
        power_q <= power_d;
      end
      if (en) begin
        s1_q <= '{valid: accept, power: power_d};
      end
    end
  end

  tcsi_interp #(
    .FRAC_BITS (SPEED_FRACTION_BITS)
  ) u_interp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .stg_i   (s1_q),
    .spd_i   (spd_q),
    .stg_o   (stg_out),
    .speed_o (speed)
  );

  assign res.valid          = stg_out.valid;
  assign res.throttle_power = stg_out.power;
  assign res.speed_q8       = speed;

endmodule

// ===== sv/tcsi_checker.sv =====
// port-level checks for the throttle clamp and speed interpolator
`include "throttle_clamp_speed_interpolator_top_assert.svh"

module tcsi_checker import tcsi_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             req_valid_i,
  input logic             req_ready_i,
  input logic             res_valid_i,
  input logic             res_ready_i,
  input logic [PWR_W-1:0] res_power_i,
  input logic [OUT_W-1:0] res_speed_i
);

  // stalled result holds
  `TCSI_ASSERT(res_hold_a, res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_power_i) && $stable(res_speed_i))

  // request side stalls exactly when a result waits
  `TCSI_ASSERT(ready_a, req_ready_i == (!res_valid_i || res_ready_i))

  // power beyond the last breakpoint has no speed
  `TCSI_ASSERT(over_zero_a, res_valid_i && (res_power_i > BP_T[NUM_PTS-1]) |-> res_speed_i == '0)

endmodule

bind throttle_clamp_speed_interpolator_top tcsi_checker u_tcsi_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req.valid),
  .req_ready_i (req.ready),
  .res_valid_i (res.valid),
  .res_ready_i (res.ready),
  .res_power_i (res.throttle_power),
  .res_speed_i (res.speed_q8)
);

// ===== tb/tcsi_speed_checker.sv =====
// throttle power and speed predictor that checks every result against its request
`timescale 1ns / 1ps

module tcsi_speed_checker import tcsi_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  tcsi_req_if              req,
  tcsi_res_if              res,
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  output int unsigned      outstanding_o,
  output int unsigned      fail_count_o
);

  localparam int FRAC_BITS   = 8;
  localparam int REPORT_MAX  = 10;
  localparam int KNEE_T [5]  = '{0, 32, 64, 96, 127};
  localparam longint SPEED_SAT = 64'hFF_FFFF;

  typedef struct packed {
    logic [PWR_W-1:0] power;
    logic [OUT_W-1:0] speed;
  } drive_result_t;

  logic [PWR_W-1:0] cap_q;
  logic [PWR_W-1:0] base_q;
  logic [PWR_W-1:0] step_q;
  logic [PWR_W-1:0] power_q;
  logic [SPD_W-1:0] knee_speed_q [NUM_PTS];
  drive_result_t    expected_q [$];
  int unsigned      fail_count;

  function automatic logic [PWR_W-1:0] bound_power(int cand);
    if (cand > int'(cap_q)) return cap_q;
    if (cand > 0 && cand <= int'(base_q)) return base_q;
    if (cand < 0) return '0;
    return cand[PWR_W-1:0];
  endfunction

  function automatic logic [PWR_W-1:0] next_power(kind_e kind,
                                                   logic signed [REQ_W-1:0] ask);
    case (kind)
      KIND_SET: return bound_power(int'(ask));
      KIND_INC: begin
        if (power_q == '0) return bound_power(int'(base_q));
        return bound_power(int'(power_q) + int'(step_q));
      end
      KIND_DEC: begin
        if (power_q <= base_q) return bound_power(0);
        return bound_power(int'(power_q) - int'(step_q));
      end
      default: return power_q;
    endcase
  endfunction

  function automatic logic [OUT_W-1:0] speed_at_power(logic [PWR_W-1:0] t);
    longint tv, lo_t, hi_t, span, s0, s1, num, q;
    tv = longint'(t);
    for (int i = 0; i < NUM_PTS - 1; i++) begin
      lo_t = KNEE_T[i];
      hi_t = KNEE_T[i+1];
      if (tv >= lo_t && tv <= hi_t) begin
        span = hi_t - lo_t;
        s0   = longint'(knee_speed_q[i]);
        s1   = longint'(knee_speed_q[i+1]);
        num  = s0 * span + (s1 - s0) * (tv - lo_t);
        if (num < 0) num = 0;
        q = (num <<< FRAC_BITS) / span;
        if (q > SPEED_SAT) q = SPEED_SAT;
        return q[OUT_W-1:0];
      end
    end
    return '0;
  endfunction

  function automatic void note_failure(string what, drive_result_t want, drive_result_t got);
    fail_count++;
    if (fail_count <= REPORT_MAX) begin
      $display("%0t %s: power exp %0d got %0d, speed exp %0d got %0d", $realtime, what,
               want.power, got.power, want.speed, got.speed);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    drive_result_t got;
    drive_result_t want;
    if (!rst_ni) begin
      cap_q        = LIMIT_RST;
      base_q       = FLOOR_RST;
      step_q       = STEP_RST;
      knee_speed_q = SPEED_RST;
      power_q      = '0;
      expected_q.delete();
      fail_count   = 0;
    end else begin
      if (res.valid && res.ready) begin
        got = '{power: res.throttle_power, speed: res.speed_q8};
        if (expected_q.size() == 0) begin
          note_failure("unexpected result", '0, got);
        end else begin
          want = expected_q.pop_front();
          if (got.power !== want.power || got.speed !== want.speed) begin
            note_failure("result mismatch", want, got);
          end
        end
      end
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_idx_i))
          REG_LIMIT:  cap_q           = cfg_wdata_i[PWR_W-1:0];
          REG_FLOOR:  base_q          = cfg_wdata_i[PWR_W-1:0];
          REG_STEP:   step_q          = cfg_wdata_i[PWR_W-1:0];
          REG_SPD0:   knee_speed_q[0] = cfg_wdata_i[SPD_W-1:0];
          REG_SPD32:  knee_speed_q[1] = cfg_wdata_i[SPD_W-1:0];
          REG_SPD64:  knee_speed_q[2] = cfg_wdata_i[SPD_W-1:0];
          REG_SPD96:  knee_speed_q[3] = cfg_wdata_i[SPD_W-1:0];
          REG_SPD127: knee_speed_q[4] = cfg_wdata_i[SPD_W-1:0];
          default: ;
        endcase
      end
      if (req.valid && req.ready) begin
        power_q = next_power(kind_e'(req.kind), req.requested_throttle);
        expected_q.push_back('{power: power_q, speed: speed_at_power(power_q)});
      end
    end
    outstanding_o <= expected_q.size();
    fail_count_o  <= fail_count;
  end

endmodule

// ===== tb/tb_throttle_clamp_speed_interpolator_top.sv =====
// testbench top: drives requests and register writes, stalls the result side, gives the verdict
`timescale 1ns / 1ps

module tb_throttle_clamp_speed_interpolator_top;
  import tcsi_pkg::*;

  typedef logic [CFG_W-1:0] reg_file_t [8];

  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int          RANDOM_PHASES = 7;
  localparam int          PHASE_ITEMS   = 150;
  localparam int          TAIL_CYCLES   = 10;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we;
  logic [IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0] cfg_wdata;
  int unsigned      outstanding;
  int unsigned      fail_count;
  int unsigned      idle_cycles = 0;
  bit               sender_calm = 1'b0;
  reg_file_t        regs_now;

  tcsi_req_if req_ch ();
  tcsi_res_if res_ch ();

  throttle_clamp_speed_interpolator_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req         (req_ch),
    .res         (res_ch),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  tcsi_speed_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req           (req_ch),
    .res           (res_ch),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .outstanding_o (outstanding),
    .fail_count_o  (fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [PWR_W-1:0] pick_byte();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return PWR_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic reg_file_t random_registers();
    reg_file_t        v;
    logic [PWR_W-1:0] cap;
    logic [PWR_W-1:0] base;
    logic [PWR_W-1:0] step;
    cap = pick_byte();
    case ($urandom_range(0, 9))
      0:       base = '0;
      1:       base = '1;
      2, 3:    base = (cap == '1) ? cap : PWR_W'($urandom_range(int'(cap) + 1, 255));
      default: base = PWR_W'($urandom_range(0, int'(cap)));
    endcase
    case ($urandom_range(0, 9))
      0:       step = '0;
      1:       step = '1;
      default: step = PWR_W'($urandom_range(1, 40));
    endcase
    // upper byte of the narrow registers is junk and must be dropped
    v[REG_LIMIT] = {PWR_W'($urandom_range(0, 255)), cap};
    v[REG_FLOOR] = {PWR_W'($urandom_range(0, 255)), base};
    v[REG_STEP]  = {PWR_W'($urandom_range(0, 255)), step};
    for (int i = REG_SPD0; i <= REG_SPD127; i++) begin
      case ($urandom_range(0, 9))
        0:       v[i] = '0;
        1:       v[i] = '1;
        default: v[i] = CFG_W'($urandom_range(0, 65535));
      endcase
    end
    return v;
  endfunction

  function automatic int pick_request();
    int cap;
    int base;
    cap  = int'(regs_now[REG_LIMIT][PWR_W-1:0]);
    base = int'(regs_now[REG_FLOOR][PWR_W-1:0]);
    case ($urandom_range(0, 3))
      0:       return base + int'($urandom_range(0, 4)) - 2;
      1:       return cap + int'($urandom_range(0, 4)) - 2;
      default: return int'($urandom_range(0, 511)) - 256;
    endcase
  endfunction

  function automatic kind_e pick_kind();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return KIND_SET;
    if (r < 65) return KIND_INC;
    if (r < 90) return KIND_DEC;
    return KIND_HOLD;
  endfunction

  task automatic send_request(kind_e kind, int value);
    int unsigned gap;
    gap = sender_calm ? 0 : pick_gap();
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid              <= 1'b1;
    req_ch.kind               <= kind;
    req_ch.requested_throttle <= value[REQ_W-1:0];
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
  endtask

  task automatic await_results();
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  task automatic load_registers(reg_file_t vals);
    await_results();
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= reg_idx_e'(i);
      cfg_wdata <= vals[i];
      @(posedge clk_i);
    end
    cfg_we   <= 1'b0;
    regs_now = vals;
  endtask

  // result side back-pressure
  initial begin
    int unsigned open_len;
    int unsigned gap;
    res_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      open_len = ($urandom_range(0, 19) == 0) ? 300 : $urandom_range(1, 30);
      res_ch.ready <= 1'b1;
      repeat (open_len) @(posedge clk_i);
      gap = pick_gap();
      if (gap != 0) begin
        res_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && !cfg_we && !(req_ch.valid && req_ch.ready) &&
        !(res_ch.valid && res_ch.ready)) begin
      idle_cycles <= idle_cycles + 1;
    end else begin
      idle_cycles <= 0;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL throttle_clamp_speed_interpolator_top");
      $finish;
    end
  end

  initial begin
    rst_ni                    <= 1'b0;
    cfg_we                    <= 1'b0;
    cfg_idx                   <= REG_LIMIT;
    cfg_wdata                 <= '0;
    req_ch.valid              <= 1'b0;
    req_ch.kind               <= KIND_SET;
    req_ch.requested_throttle <= '0;
    regs_now = '{{8'h00, LIMIT_RST}, {8'h00, FLOOR_RST}, {8'h00, STEP_RST},
                 SPEED_RST[0], SPEED_RST[1], SPEED_RST[2], SPEED_RST[3], SPEED_RST[4]};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: floor jumps, limit clamp, negatives, breakpoints, hold
    send_request(KIND_SET, 0);
    send_request(KIND_INC, 0);
    send_request(KIND_INC, 0);
    send_request(KIND_DEC, 0);
    send_request(KIND_DEC, 0);
    send_request(KIND_DEC, 0);
    send_request(KIND_SET, 255);
    send_request(KIND_INC, 0);
    send_request(KIND_SET, -256);
    send_request(KIND_SET, -1);
    send_request(KIND_SET, 1);
    send_request(KIND_SET, 33);
    send_request(KIND_SET, 96);
    send_request(KIND_HOLD, -1);
    send_request(KIND_SET, 127);

    // wide open: power above the last breakpoint, zero floor, full step
    load_registers('{16'hFFFF, 16'hFF00, 16'h00FF, 16'hFFFF, 16'h0000,
                     16'hFFFF, 16'h0000, 16'hFFFF});
    send_request(KIND_SET, 255);
    send_request(KIND_SET, 128);
    send_request(KIND_SET, 1);
    send_request(KIND_DEC, 0);
    send_request(KIND_INC, 0);
    send_request(KIND_SET, 200);
    send_request(KIND_INC, 0);

    // floor above limit, zero step
    load_registers('{16'h5514, 16'hAA32, 16'h0000, 16'd100, 16'd200,
                     16'd300, 16'd400, 16'd500});
    send_request(KIND_SET, 10);
    send_request(KIND_SET, 30);
    send_request(KIND_INC, 0);
    send_request(KIND_DEC, 0);
    send_request(KIND_INC, 0);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      load_registers(random_registers());
      sender_calm = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_request(pick_kind(), pick_request());
      end
    end

    await_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS throttle_clamp_speed_interpolator_top");
    end else begin
      $display("FAIL throttle_clamp_speed_interpolator_top");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/tcsi_pkg.sv
sv/tcsi_req_if.sv
sv/tcsi_res_if.sv
sv/tcsi_interp.sv
sv/throttle_clamp_speed_interpolator_top.sv
sv/tcsi_checker.sv
tb/tcsi_speed_checker.sv
tb/tb_throttle_clamp_speed_interpolator_top.sv
